[design/pkseg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkseg_pkg
// Shared constants and types for the packet segmenter.
// ----------------------------------------------------------------------------
package pkseg_pkg;

    localparam int unsigned HDR_BYTES        = 28;
    localparam int unsigned HDR_IDX_W        = $clog2(HDR_BYTES);
    localparam int unsigned QUEUE_DEPTH      = 2;
    localparam logic [15:0] MBS_RESET        = 16'd1500;
    localparam logic [15:0] MBS_MIN          = 16'(HDR_BYTES + 1);
    localparam logic [1:0]  ADDR_BLOCK_LIMIT = 2'd0;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_header;
        logic        block_end;
        logic        packet_end;
        logic [63:0] seq;
        logic [31:0] total;
        logic [31:0] offset;
        logic [31:0] number;
        logic [31:0] count;
        logic [15:0] len;
    } t_cmd;

endpackage

[design/pkseg_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkseg_div
// Restoring divider, one quotient bit per cycle, 32 by 16 bits.
// ----------------------------------------------------------------------------
module pkseg_div
    import pkseg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient,
    output logic [15:0] o_remainder
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [31:0] r_quo;
    logic [15:0] r_div;
    logic [16:0] w_trial;
    logic [16:0] w_diff;
    logic        w_bit;

    assign w_trial = {r_rem, r_quo[31]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_bit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_bit ? w_diff[15:0] : w_trial[15:0];
            r_quo <= {r_quo[30:0], w_bit};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[design/pkseg_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkseg_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module pkseg_fifo
    import pkseg_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[design/pkseg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkseg_front
// Accepts payload bytes, tracks packet and block state, queues commands.
// ----------------------------------------------------------------------------
module pkseg_front
    import pkseg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tvalid,
    output logic        o_tready,
    input  logic [7:0]  i_payload_byte,
    input  logic [31:0] i_packet_bytes,
    input  logic [15:0] i_block_limit,
    output logic        o_push,
    output t_cmd        o_cmd,
    input  logic        i_full
);

    typedef enum logic [1:0] {
        S_RUN,
        S_DIV,
        S_PUSH
    } t_state;

    t_state      r_state,        n_state;
    logic [63:0] r_seq,          n_seq;
    logic [31:0] r_total,        n_total;
    logic [31:0] r_remaining,    n_remaining;
    logic [31:0] r_offset,       n_offset;
    logic [31:0] r_number,       n_number;
    logic [31:0] r_block_total,  n_block_total;
    logic [15:0] r_block_left,   n_block_left;
    logic [7:0]  r_byte,         n_byte;

    logic        w_first;
    logic        w_step;
    logic        w_div_start;
    logic        w_div_done;
    logic [31:0] w_quo;
    logic [15:0] w_rem;
    logic [15:0] w_psize;
    logic [15:0] w_mbs;
    logic        w_hdr;
    logic [15:0] w_len;
    logic [31:0] w_offset;
    logic [15:0] w_bl_new;
    logic [31:0] w_rem_new;
    logic        w_be;
    logic        w_pe;

    pkseg_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (i_packet_bytes),
        .i_divisor   (w_psize),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    assign w_mbs    = (i_block_limit < MBS_MIN) ? MBS_MIN : i_block_limit;
    assign w_psize  = w_mbs - 16'(HDR_BYTES);
    assign w_first  = (r_remaining == '0);
    assign o_tready = (r_state == S_RUN) && (w_first || !i_full);

    assign w_hdr     = (r_block_left == '0);
    assign w_len     = !w_hdr ? r_block_left :
                       (r_remaining < {16'd0, w_psize}) ? r_remaining[15:0] : w_psize;
    assign w_offset  = w_hdr ? (r_total - r_remaining) : r_offset;
    assign w_bl_new  = w_len - 16'd1;
    assign w_rem_new = r_remaining - 32'd1;
    assign w_be      = (w_bl_new == '0);
    assign w_pe      = (w_rem_new == '0);

    always_comb begin
        n_state       = r_state;
        n_seq         = r_seq;
        n_total       = r_total;
        n_remaining   = r_remaining;
        n_offset      = r_offset;
        n_number      = r_number;
        n_block_total = r_block_total;
        n_block_left  = r_block_left;
        n_byte        = r_byte;
        w_step        = 1'b0;
        w_div_start   = 1'b0;

        unique case (r_state)
            S_RUN: begin
                if (i_tvalid && o_tready) begin
                    if (w_first) begin
                        if (i_packet_bytes != '0) begin
                            n_total      = i_packet_bytes;
                            n_remaining  = i_packet_bytes;
                            n_number     = '0;
                            n_offset     = '0;
                            n_block_left = '0;
                            n_byte       = i_payload_byte;
                            n_state      = S_DIV;
                        end
                    end else begin
                        w_step = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_block_total = w_quo + {31'd0, (w_rem != '0)};
                    n_state       = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_full) begin
                    w_step  = 1'b1;
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase

        if (r_state == S_RUN && n_state == S_DIV) begin
            w_div_start = 1'b1;
        end

        if (w_step) begin
            n_remaining  = w_rem_new;
            n_offset     = w_offset;
            n_block_left = w_pe ? 16'd0 : w_bl_new;
            if (w_be) begin
                n_number = r_number + 32'd1;
            end
            if (w_pe) begin
                n_seq = r_seq + 64'd1;
            end
        end
    end

    always_comb begin
        o_push           = w_step;
        o_cmd.data_byte  = (r_state == S_PUSH) ? r_byte : i_payload_byte;
        o_cmd.is_header  = w_hdr;
        o_cmd.block_end  = w_be;
        o_cmd.packet_end = w_pe;
        o_cmd.seq        = r_seq;
        o_cmd.total      = r_total;
        o_cmd.offset     = w_offset;
        o_cmd.number     = r_number;
        o_cmd.count      = r_block_total;
        o_cmd.len        = w_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_RUN;
            r_seq         <= '0;
            r_total       <= '0;
            r_remaining   <= '0;
            r_offset      <= '0;
            r_number      <= '0;
            r_block_total <= '0;
            r_block_left  <= '0;
            r_byte        <= '0;
        end else begin
            r_state       <= n_state;
            r_seq         <= n_seq;
            r_total       <= n_total;
            r_remaining   <= n_remaining;
            r_offset      <= n_offset;
            r_number      <= n_number;
            r_block_total <= n_block_total;
            r_block_left  <= n_block_left;
            r_byte        <= n_byte;
        end
    end

endmodule

[design/pkseg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkseg_back
// Pops queued commands and emits header and payload bytes on the output.
// ----------------------------------------------------------------------------
module pkseg_back
    import pkseg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_out_byte,
    output logic       o_is_header,
    output logic       o_block_end,
    output logic       o_packet_end,
    output logic       o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HDR,
        S_PAY
    } t_state;

    localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_BYTES - 1);

    t_state               r_state,      n_state;
    t_cmd                 r_cmd,        n_cmd;
    logic [HDR_IDX_W-1:0] r_idx,        n_idx;
    logic                 r_tvalid,     n_tvalid;
    logic [7:0]           r_out_byte,   n_out_byte;
    logic                 r_is_header,  n_is_header;
    logic                 r_block_end,  n_block_end;
    logic                 r_packet_end, n_packet_end;
    logic                 r_last,       n_last;

    logic                      w_slot;
    logic [HDR_BYTES*8-1:0]    w_hdr_vec;
    logic [7:0]                w_hdr [HDR_BYTES];

    assign w_slot    = !r_tvalid || i_tready;
    assign w_hdr_vec = {r_cmd.seq, r_cmd.total, r_cmd.offset, r_cmd.number,
                        r_cmd.count, 16'd0, r_cmd.len};

    always_comb begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            w_hdr[i] = w_hdr_vec[(HDR_BYTES - 1 - i) * 8 +: 8];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_tvalid     = r_tvalid && !i_tready;
        n_out_byte   = r_out_byte;
        n_is_header  = r_is_header;
        n_block_end  = r_block_end;
        n_packet_end = r_packet_end;
        n_last       = r_last;
        o_pop        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_idx   = '0;
                    n_state = i_cmd.is_header ? S_HDR : S_PAY;
                end
            end
            S_HDR: begin
                if (w_slot) begin
                    n_tvalid     = 1'b1;
                    n_out_byte   = w_hdr[r_idx];
                    n_is_header  = 1'b1;
                    n_block_end  = 1'b0;
                    n_packet_end = 1'b0;
                    n_last       = 1'b0;
                    if (r_idx == HDR_LAST) begin
                        n_state = S_PAY;
                    end else begin
                        n_idx = r_idx + HDR_IDX_W'(1);
                    end
                end
            end
            S_PAY: begin
                if (w_slot) begin
                    n_tvalid     = 1'b1;
                    n_out_byte   = r_cmd.data_byte;
                    n_is_header  = 1'b0;
                    n_block_end  = r_cmd.block_end;
                    n_packet_end = r_cmd.packet_end;
                    n_last       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tvalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_tvalid <= n_tvalid;
            r_idx    <= n_idx;
        end
        r_cmd        <= n_cmd;
        r_out_byte   <= n_out_byte;
        r_is_header  <= n_is_header;
        r_block_end  <= n_block_end;
        r_packet_end <= n_packet_end;
        r_last       <= n_last;
    end

    assign o_tvalid     = r_tvalid;
    assign o_out_byte   = r_out_byte;
    assign o_is_header  = r_is_header;
    assign o_block_end  = r_block_end;
    assign o_packet_end = r_packet_end;
    assign o_last       = r_last;

endmodule

[design/packet_segmenter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_segmenter
// Splits a byte stream into blocks, each led by a 28-byte big-endian header.
// In the output stage a byte inside a block is first popped, then emitted.
// A byte that opens a block is popped, then its header bytes are emitted, then the byte itself.
// The first byte of a packet first waits for the 32-step block count divider.
// An accepted byte reaches the output through the queue memory, the command register and the output register.
// Reset is synchronous, active low, and clears all packet state; the block limit returns to 1500.
// ----------------------------------------------------------------------------
module packet_segmenter
    import pkseg_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // payload_byte, packet_bytes
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic [2:0]  m_axis_tuser,   // is_header, block_end, packet_end
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_block_limit;
    logic        w_push;
    logic        w_full;
    logic        w_pop;
    logic        w_empty;
    t_cmd        w_cmd_in;
    t_cmd        w_cmd_out;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BLOCK_LIMIT) ? {16'd0, r_block_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_limit <= MBS_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_BLOCK_LIMIT)) begin
            r_block_limit <= pwdata[15:0];
        end
    end

    pkseg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tvalid       (s_axis_tvalid),
        .o_tready       (s_axis_tready),
        .i_payload_byte (s_axis_tdata[7:0]),
        .i_packet_bytes (s_axis_tdata[39:8]),
        .i_block_limit  (r_block_limit),
        .o_push         (w_push),
        .o_cmd          (w_cmd_in),
        .i_full         (w_full)
    );

    pkseg_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_empty)
    );

    pkseg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_cmd        (w_cmd_out),
        .o_pop        (w_pop),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_out_byte   (m_axis_tdata),
        .o_is_header  (m_axis_tuser[0]),
        .o_block_end  (m_axis_tuser[1]),
        .o_packet_end (m_axis_tuser[2]),
        .o_last       (m_axis_tlast)
    );

endmodule
